// ----- hw/rtl/bsop_pkg.sv -----
// Shared types, field widths and helper functions for the bit-vector set engine.
// Used by the channel interfaces and the engine core; depends on nothing else.
`timescale 1ns / 1ps

package bsop_pkg;

  // Default sizing of the set store.
  localparam int SET_BITS_DEF  = 1024;
  localparam int NUM_SETS_DEF  = 8;
  localparam int WORD_BITS_DEF = 64;

  // Fixed field widths of the command and response transactions.
  localparam int MODE_W  = 4;
  localparam int SETID_W = 3;
  localparam int ELEM_W  = 10;
  localparam int COUNT_W = 11;
  localparam int SIZE_W  = 11;

  // Reset value of the set size register.
  localparam int SIZE_RESET = 1024;

  // Population count result width for a word of up to 64 bits.
  localparam int POP_W = 7;

  // Operation codes. Codes 13 to 15 are unused and do nothing.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 4'd0,
    MODE_REMOVE   = 4'd1,
    MODE_MEMBER   = 4'd2,
    MODE_CLEAR    = 4'd3,
    MODE_FILL     = 4'd4,
    MODE_COPY     = 4'd5,
    MODE_INTERSECT = 4'd6,
    MODE_UNION    = 4'd7,
    MODE_DIFF     = 4'd8,
    MODE_COMPL    = 4'd9,
    MODE_ADD_COMPL = 4'd10,
    MODE_SUBSET   = 4'd11,
    MODE_COUNT    = 4'd12
  } mode_t;

  // Engine control states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Number of ones in a word of up to 64 bits.
  function automatic logic [POP_W-1:0] popcount(input logic [63:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

  // Set index reduced modulo the number of sets, by repeated subtraction.
  function automatic logic [SETID_W-1:0] set_mod(input logic [SETID_W-1:0] v,
                                                 input int unsigned n);
    logic [SETID_W-1:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= int'(n)) begin
        r = SETID_W'(int'(r) - int'(n));
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bsop_in_if.sv -----
// Command channel of the bit-vector set engine: valid/ready plus one operation.
// Depends on bsop_pkg for the field widths.
`timescale 1ns / 1ps

interface bsop_in_if;
  logic                              valid;
  logic                              ready;
  logic [bsop_pkg::MODE_W-1:0]       mode;
  logic [bsop_pkg::SETID_W-1:0]      dest_set;
  logic [bsop_pkg::SETID_W-1:0]      src_a;
  logic [bsop_pkg::SETID_W-1:0]      src_b;
  logic [bsop_pkg::ELEM_W-1:0]       element;

  modport source (output valid, output mode, output dest_set, output src_a,
                  output src_b, output element, input ready);
  modport sink   (input valid, input mode, input dest_set, input src_a,
                  input src_b, input element, output ready);
endinterface

// ----- hw/rtl/bsop_out_if.sv -----
// Response channel of the bit-vector set engine: valid/ready plus one result.
// Depends on bsop_pkg for the field widths.
`timescale 1ns / 1ps

interface bsop_out_if;
  logic                              valid;
  logic                              ready;
  logic                              flag;
  logic [bsop_pkg::COUNT_W-1:0]      count;
  logic                              range_error;

  modport source (output valid, output flag, output count, output range_error,
                  input ready);
  modport sink   (input valid, input flag, input count, input range_error,
                  output ready);
endinterface

// ----- hw/rtl/bitset_set_operation_engine_core.sv -----
// Bit-vector set engine: set store memory, word walker and response register.
// Depends on bsop_pkg, bsop_in_if and bsop_out_if.
`timescale 1ns / 1ps

// The engine keeps NUM_SETS sets of SET_BITS elements in one word memory of
// NUM_SETS * ceil(SET_BITS / WORD_BITS) words with two read ports and one
// write port. After reset a clearing pass writes zero to every word, one
// word per cycle, and no command is taken until it ends. Every command
// then walks all words of its sets, one word per cycle through a read,
// modify and write-back pipeline of two stages. A finished response waits
// in its own output register, so the next command is taken while the
// previous response is still unclaimed. Element commands whose element
// lies at or above the set size in use change nothing and report a range
// error. The set size register may be written only while the engine is
// idle.
module bitset_set_operation_engine_core #(
  parameter int SET_BITS  = bsop_pkg::SET_BITS_DEF,
  parameter int NUM_SETS  = bsop_pkg::NUM_SETS_DEF,
  parameter int WORD_BITS = bsop_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bsop_pkg::SIZE_W-1:0] cfg_wdata,
  bsop_in_if.sink                     cmd,
  bsop_out_if.source                  res
);

  localparam int WPS     = (SET_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH   = NUM_SETS * WPS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIDX_W  = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int OFF_W   = $clog2(WORD_BITS);
  localparam int LO_MAX  = (WPS + 1) * WORD_BITS;
  localparam int CMP_W   = ($clog2(LO_MAX + 1) > 12) ? $clog2(LO_MAX + 1) : 12;

  // Set size register.
  logic [bsop_pkg::SIZE_W-1:0] set_size;
  logic [CMP_W-1:0]            size_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size <= bsop_pkg::SIZE_W'(bsop_pkg::SIZE_RESET);
    end else if (cfg_we) begin
      set_size <= cfg_wdata;
    end
  end

  assign size_used = (CMP_W'(set_size) > CMP_W'(SET_BITS)) ? CMP_W'(SET_BITS)
                                                           : CMP_W'(set_size);

  // Control state and command registers.
  bsop_pkg::state_t            state, state_next;
  bsop_pkg::mode_t             op_mode;
  logic [bsop_pkg::ELEM_W-1:0] op_elem;
  logic                        op_rerr;
  logic                        op_binop;
  logic [ADDR_W-1:0]           base_d, base_a, base_b;
  logic [ADDR_W-1:0]           clr_cnt;
  logic                        clr_last;

  // Word walker and pipeline registers.
  logic                        iss_on;
  logic [WIDX_W-1:0]           iss_w;
  logic [CMP_W-1:0]            iss_lo;
  logic                        iss_last;
  logic                        s1_v, s1_last;
  logic [WIDX_W-1:0]           s1_w;
  logic [CMP_W-1:0]            s1_lo;
  logic                        s2_v, s2_last;
  logic [WORD_BITS-1:0]        s2_word;
  logic                        s2_viol, s2_hit;

  // Accumulators and output register.
  logic [bsop_pkg::COUNT_W-1:0] acc_cnt, acc_cnt_next;
  logic                         acc_flag, acc_flag_next;
  logic                         out_valid;
  logic                         out_flag;
  logic [bsop_pkg::COUNT_W-1:0] out_count;
  logic                         out_rerr;

  // Control strobes.
  logic cmd_accept, clr_we, issue, load_out;

  // Memory ports.
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd0, rd1;
  logic [ADDR_W-1:0]    ra0, ra1, wa;
  logic [WORD_BITS-1:0] wd;
  logic                 we;

  // Stage-one datapath results.
  logic                 s1_we;
  logic [WORD_BITS-1:0] s1_wd;
  logic [WORD_BITS-1:0] s1_cnt_word;
  logic                 s1_viol, s1_hit;
  logic [WORD_BITS-1:0] live_mask, bit_mask;
  logic                 elem_hit;
  logic [CMP_W-1:0]     elem_ext, rem, elem_rel;

  // Command decode at acceptance.
  logic [bsop_pkg::SETID_W-1:0] d_mod, a_mod, b_mod;
  logic                         new_rerr, new_binop;

  assign d_mod = bsop_pkg::set_mod(cmd.dest_set, NUM_SETS);
  assign a_mod = bsop_pkg::set_mod(cmd.src_a, NUM_SETS);
  assign b_mod = bsop_pkg::set_mod(cmd.src_b, NUM_SETS);

  assign new_rerr  = (cmd.mode <= bsop_pkg::MODE_W'(bsop_pkg::MODE_MEMBER)) &&
                     (CMP_W'(cmd.element) >= size_used);
  assign new_binop = (cmd.mode == bsop_pkg::MODE_W'(bsop_pkg::MODE_INTERSECT)) ||
                     (cmd.mode == bsop_pkg::MODE_W'(bsop_pkg::MODE_UNION)) ||
                     (cmd.mode == bsop_pkg::MODE_W'(bsop_pkg::MODE_DIFF));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      bsop_pkg::ST_CLEAR: begin
        if (clr_last) state_next = bsop_pkg::ST_IDLE;
      end
      bsop_pkg::ST_IDLE: begin
        if (cmd.valid) state_next = bsop_pkg::ST_RUN;
      end
      bsop_pkg::ST_RUN: begin
        if (s2_v && s2_last) state_next = bsop_pkg::ST_DONE;
      end
      bsop_pkg::ST_DONE: begin
        if (!out_valid || res.ready) state_next = bsop_pkg::ST_IDLE;
      end
      default: state_next = bsop_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    cmd.ready = 1'b0;
    clr_we    = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      bsop_pkg::ST_CLEAR: clr_we    = 1'b1;
      bsop_pkg::ST_IDLE:  cmd.ready = 1'b1;
      bsop_pkg::ST_RUN:   issue     = iss_on;
      bsop_pkg::ST_DONE:  load_out  = !out_valid || res.ready;
      default: ;
    endcase
  end

  assign cmd_accept = cmd.valid && cmd.ready;
  assign clr_last   = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign iss_last   = (iss_w == WIDX_W'(WPS - 1));

  // State register and clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bsop_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clr_we) clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Command registers; set bases are word addresses of word zero of each set.
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      op_mode  <= bsop_pkg::mode_t'(cmd.mode);
      op_elem  <= cmd.element;
      op_rerr  <= new_rerr;
      op_binop <= new_binop;
      base_d   <= ADDR_W'(d_mod) * ADDR_W'(WPS);
      base_a   <= ADDR_W'(a_mod) * ADDR_W'(WPS);
      base_b   <= ADDR_W'(b_mod) * ADDR_W'(WPS);
    end
  end

  // Word walker: issues one read per cycle for each word of the set.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_on <= 1'b0;
    end else if (cmd_accept) begin
      iss_on <= 1'b1;
    end else if (issue && iss_last) begin
      iss_on <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      iss_w  <= '0;
      iss_lo <= '0;
    end else if (issue) begin
      iss_w  <= iss_w + WIDX_W'(1);
      iss_lo <= iss_lo + CMP_W'(WORD_BITS);
    end
  end

  // Read addresses: port one always reads src_a, port zero reads src_b for
  // intersect, union and difference, and the destination otherwise.
  assign ra0 = (op_binop ? base_b : base_d) + ADDR_W'(iss_w);
  assign ra1 = base_a + ADDR_W'(iss_w);

  // Set store with registered reads.
  assign we = clr_we || s1_we;
  assign wa = clr_we ? clr_cnt : (base_d + ADDR_W'(s1_w));
  assign wd = clr_we ? '0 : s1_wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  // Stage one control: marks the word whose read data arrives this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= iss_last;
    s1_w    <= iss_w;
    s1_lo   <= iss_lo;
  end

  // Masks for this word: positions below the size in use, and the element bit.
  assign rem      = size_used - s1_lo;
  assign elem_ext = CMP_W'(op_elem);
  assign elem_rel = elem_ext - s1_lo;
  assign elem_hit = (elem_ext >= s1_lo) && (elem_ext < s1_lo + CMP_W'(WORD_BITS));
  assign bit_mask = WORD_BITS'(1) << elem_rel[OFF_W-1:0];

  always_comb begin
    if (size_used <= s1_lo) begin
      live_mask = '0;
    end else if (rem >= CMP_W'(WORD_BITS)) begin
      live_mask = '1;
    end else begin
      live_mask = ~({WORD_BITS{1'b1}} << rem[OFF_W-1:0]);
    end
  end

  // Stage one datapath: modify the word and write it back, or evaluate it.
  always_comb begin
    s1_we       = 1'b0;
    s1_wd       = '0;
    s1_cnt_word = '0;
    s1_viol     = 1'b0;
    s1_hit      = 1'b0;
    unique case (op_mode)
      bsop_pkg::MODE_ADD: begin
        s1_we = elem_hit && !op_rerr;
        s1_wd = rd0 | bit_mask;
      end
      bsop_pkg::MODE_REMOVE: begin
        s1_we = elem_hit && !op_rerr;
        s1_wd = rd0 & ~bit_mask;
      end
      bsop_pkg::MODE_MEMBER: begin
        s1_hit = elem_hit && !op_rerr && |(rd0 & bit_mask);
      end
      bsop_pkg::MODE_CLEAR: begin
        s1_we = 1'b1;
        s1_wd = '0;
      end
      bsop_pkg::MODE_FILL: begin
        s1_we = 1'b1;
        s1_wd = '1;
      end
      bsop_pkg::MODE_COPY: begin
        s1_we = 1'b1;
        s1_wd = rd1;
      end
      bsop_pkg::MODE_INTERSECT: begin
        s1_we = 1'b1;
        s1_wd = rd1 & rd0;
      end
      bsop_pkg::MODE_UNION: begin
        s1_we = 1'b1;
        s1_wd = rd1 | rd0;
      end
      bsop_pkg::MODE_DIFF: begin
        s1_we = 1'b1;
        s1_wd = rd1 & ~rd0;
      end
      bsop_pkg::MODE_COMPL: begin
        s1_we = 1'b1;
        s1_wd = ~rd1;
      end
      bsop_pkg::MODE_ADD_COMPL: begin
        s1_we = 1'b1;
        s1_wd = rd0 | ~rd1;
      end
      bsop_pkg::MODE_SUBSET: begin
        s1_viol = |(rd0 & ~rd1 & live_mask);
      end
      bsop_pkg::MODE_COUNT: begin
        s1_cnt_word = rd0 & live_mask;
      end
      default: ;
    endcase
    if (!s1_v) s1_we = 1'b0;
  end

  // Stage two: register the per-word results ahead of the population count.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_last <= s1_last;
    s2_word <= s1_cnt_word;
    s2_viol <= s1_viol;
    s2_hit  <= s1_hit;
  end

  // Accumulate the count, and the member or subset flag, over all words.
  always_comb begin
    acc_cnt_next  = acc_cnt +
                    bsop_pkg::COUNT_W'(bsop_pkg::popcount(64'(s2_word)));
    acc_flag_next = (acc_flag || s2_hit) && !s2_viol;
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      acc_cnt  <= '0;
      acc_flag <= (cmd.mode == bsop_pkg::MODE_W'(bsop_pkg::MODE_SUBSET));
    end else if (s2_v) begin
      acc_cnt  <= acc_cnt_next;
      acc_flag <= acc_flag_next;
    end
  end

  // Response register; it holds a transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_flag  <= acc_flag;
      out_count <= acc_cnt;
      out_rerr  <= op_rerr;
    end
  end

  assign res.valid       = out_valid;
  assign res.flag        = out_flag;
  assign res.count       = out_count;
  assign res.range_error = out_rerr;

  // The engine takes a command only with the word pipeline empty.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !s1_v && !s2_v && !iss_on)
    else $error("command accepted while the word pipeline is busy");

  // A write-back never hits a word that is read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    issue && s1_we |-> (wa != ra0) && (wa != ra1))
    else $error("write-back collides with a read of the same word");

  // The last word leaving the pipeline ends the walk.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    s2_v && s2_last |=> state == bsop_pkg::ST_DONE)
    else $error("walk did not end after its last word");

  // A range error carries no flag and no count.
  a_rerr_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.range_error |-> !res.flag && (res.count == '0))
    else $error("range error response carries a flag or a count");

endmodule
